>>> rtl/spike_event_delay_buffer_top_macros.svh
// Assertion macros used by the spike event delay buffer checker.
`ifndef SPIKE_EVENT_DELAY_BUFFER_TOP_MACROS_SVH
`define SPIKE_EVENT_DELAY_BUFFER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SEDB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SEDB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sedb_pkg.sv
// Shared types, constants and helper functions of the spike event delay buffer.
package sedb_pkg;

   localparam int RING_DEPTH      = 64;
   localparam int PTR_WIDTH       = $clog2(RING_DEPTH);
   localparam int CELL_WIDTH      = 16;
   localparam int TICK_WIDTH      = 20;
   localparam int TIME_WIDTH      = 48;
   localparam int ENTRY_WIDTH     = CELL_WIDTH + TIME_WIDTH;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_TICKS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_TICKS = 1'd1;

   typedef enum logic {
      OP_SPIKE     = 1'b0,
      OP_FRAME_END = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [CELL_WIDTH-1:0]   cell_id;
      logic [TICK_WIDTH-1:0]   stime;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   function automatic logic [PTR_WIDTH-1:0] ring_next(input logic [PTR_WIDTH-1:0] ptr);
      logic [PTR_WIDTH-1:0] result;
      if (ptr == PTR_WIDTH'(RING_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_WIDTH'(1);
      end
      return result;
   endfunction

   function automatic logic [QPTR_WIDTH-1:0] queue_next(input logic [QPTR_WIDTH-1:0] ptr);
      logic [QPTR_WIDTH-1:0] result;
      if (ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + QPTR_WIDTH'(1);
      end
      return result;
   endfunction

endpackage

>>> rtl/sedb_ram.sv
// Generic single write port RAM with one registered read port.
module sedb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sedb_front.sv
// Front end: accepts request transactions, classifies them and queues them.
module sedb_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [sedb_pkg::CELL_WIDTH-1:0]  req_cell_id,
   input  logic [sedb_pkg::TICK_WIDTH-1:0]  req_spike_time,
   output logic                             q_valid,
   output sedb_pkg::item_type               q_item,
   input  logic                             q_pop
);
   import sedb_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0]  count_ff, count_in;
   logic                     push;
   item_type                 new_item;

   always_comb begin
      req_stall        = (count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH));
      push             = req_valid && !req_stall;
      new_item.op      = op_type'(req_kind);
      new_item.cell_id = req_cell_id;
      new_item.stime   = req_spike_time;
      q_valid          = (count_ff != '0);
      q_item           = entry_ff[rd_ptr_ff];
      wr_ptr_in        = push ? queue_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in        = q_pop ? queue_next(rd_ptr_ff) : rd_ptr_ff;
      count_in         = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCOUNT_WIDTH'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - QCOUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/sedb_back.sv
// Back end: spike ring, frame drain sequencer, tick registers and result register.
module sedb_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [sedb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sedb_pkg::TICK_WIDTH-1:0]      csr_wdata,
   input  logic                                 q_valid,
   input  sedb_pkg::item_type                   q_item,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sedb_pkg::CELL_WIDTH-1:0]      rsp_cell_id_out,
   output logic [sedb_pkg::TICK_WIDTH-1:0]      rsp_time_in_frame,
   output logic                                 rsp_has_spike,
   output logic                                 rsp_last,
   output logic                                 rsp_overflow
);
   import sedb_pkg::*;

   state_type               state_ff, state_in;
   logic [TICK_WIDTH-1:0]   delay_ff, frame_ticks_ff;
   logic [PTR_WIDTH-1:0]    rp_ff, rp_in, wp_ff, wp_in;
   logic [TIME_WIDTH-1:0]   frame_start_ff, frame_start_in;
   logic                    dropped_ff, dropped_in;
   logic                    have_pend_ff, have_pend_in;
   logic [CELL_WIDTH-1:0]   pend_cell_ff, pend_cell_in;
   logic [TICK_WIDTH-1:0]   pend_rel_ff, pend_rel_in;
   logic                    rsp_valid_ff;
   logic [CELL_WIDTH-1:0]   out_cell_ff, out_cell_in;
   logic [TICK_WIDTH-1:0]   out_time_ff, out_time_in;
   logic                    out_has_ff, out_has_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_ovf_ff;
   logic                    out_load;
   logic                    out_free;
   logic                    ram_we;
   logic [ENTRY_WIDTH-1:0]  ram_wdata;
   logic [ENTRY_WIDTH-1:0]  ram_rdata;
   logic [TIME_WIDTH-1:0]   due_time;
   logic [CELL_WIDTH-1:0]   head_cell;
   logic [TIME_WIDTH-1:0]   head_diff;
   logic                    head_due;
   logic [TICK_WIDTH-1:0]   head_rel;
   logic                    ring_full;

   sedb_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      ring_full = (ring_next(wp_ff) == rp_ff);
      due_time  = frame_start_ff + TIME_WIDTH'(delay_ff) + TIME_WIDTH'(q_item.stime);
      ram_wdata = {q_item.cell_id, due_time};
      head_cell = ram_rdata[ENTRY_WIDTH-1:TIME_WIDTH];
      head_diff = ram_rdata[TIME_WIDTH-1:0] - frame_start_ff;
      head_due  = head_diff[TIME_WIDTH-1] || (head_diff < TIME_WIDTH'(frame_ticks_ff));
      head_rel  = head_diff[TIME_WIDTH-1] ? '0 : head_diff[TICK_WIDTH-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_item.op == OP_FRAME_END)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (rp_ff == wp_ff) ? ST_FINISH : ST_EVAL;
         end
         ST_EVAL: begin
            if (!head_due) begin
               state_in = ST_FINISH;
            end else if (!have_pend_ff || out_free) begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop          = 1'b0;
      ram_we         = 1'b0;
      rp_in          = rp_ff;
      wp_in          = wp_ff;
      dropped_in     = dropped_ff;
      frame_start_in = frame_start_ff;
      have_pend_in   = have_pend_ff;
      pend_cell_in   = pend_cell_ff;
      pend_rel_in    = pend_rel_ff;
      out_load       = 1'b0;
      out_cell_in    = pend_cell_ff;
      out_time_in    = pend_rel_ff;
      out_has_in     = 1'b1;
      out_last_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_SPIKE) begin
                  if (ring_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     wp_in  = ring_next(wp_ff);
                  end
               end else begin
                  have_pend_in = 1'b0;
               end
            end
         end
         ST_EVAL: begin
            if (head_due && (!have_pend_ff || out_free)) begin
               out_load     = have_pend_ff;
               pend_cell_in = head_cell;
               pend_rel_in  = head_rel;
               have_pend_in = 1'b1;
               rp_in        = ring_next(rp_ff);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load       = 1'b1;
               out_last_in    = 1'b1;
               out_has_in     = have_pend_ff;
               if (!have_pend_ff) begin
                  out_cell_in = '0;
                  out_time_in = '0;
               end
               dropped_in     = 1'b0;
               frame_start_in = frame_start_ff + TIME_WIDTH'(frame_ticks_ff);
               have_pend_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         delay_ff       <= TICK_WIDTH'(1);
         frame_ticks_ff <= TICK_WIDTH'(1);
         rp_ff          <= '0;
         wp_ff          <= '0;
         frame_start_ff <= '0;
         dropped_ff     <= 1'b0;
         have_pend_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rp_ff          <= rp_in;
         wp_ff          <= wp_in;
         frame_start_ff <= frame_start_in;
         dropped_ff     <= dropped_in;
         have_pend_ff   <= have_pend_in;
         rsp_valid_ff   <= out_load || (rsp_valid_ff && rsp_stall);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DELAY_TICKS: delay_ff       <= csr_wdata;
               CSR_FRAME_TICKS: frame_ticks_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_cell_ff <= pend_cell_in;
      pend_rel_ff  <= pend_rel_in;
      if (out_load) begin
         out_cell_ff <= out_cell_in;
         out_time_ff <= out_time_in;
         out_has_ff  <= out_has_in;
         out_last_ff <= out_last_in;
         out_ovf_ff  <= dropped_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_id_out   = out_cell_ff;
   assign rsp_time_in_frame = out_time_ff;
   assign rsp_has_spike     = out_has_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_overflow      = out_ovf_ff;

endmodule

>>> rtl/spike_event_delay_buffer_top.sv
// Top level of the spike event delay buffer.
//
//   Port group  Direction  Handshake           Contents
//   req_*       in         req_valid/stall     kind, cell_id, spike_time
//   rsp_*       out        rsp_valid/stall     cell_id_out, time_in_frame, has_spike,
//                                              last, overflow
//   csr_*       in         csr_wr_en           index 0 delay_ticks, 1 frame_ticks
//
// A spike transaction is stored or dropped in the cycle that takes it from the input queue.
// A frame end taken from the queue passes through ST_READ and ST_EVAL per drained spike, then
// ST_READ, plus ST_EVAL if a spike not yet due stays at the head, as the ring RAM read at the
// head pointer is registered, and ends in ST_FINISH; result stalls can hold EVAL and FINISH.
// The two-entry input queue accepts until it is full while the back end drains or waits.
// Synchronous reset empties the ring and queue and sets both tick registers to 1.
module spike_event_delay_buffer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [sedb_pkg::CELL_WIDTH-1:0]      req_cell_id,
   input  logic [sedb_pkg::TICK_WIDTH-1:0]      req_spike_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sedb_pkg::CELL_WIDTH-1:0]      rsp_cell_id_out,
   output logic [sedb_pkg::TICK_WIDTH-1:0]      rsp_time_in_frame,
   output logic                                 rsp_has_spike,
   output logic                                 rsp_last,
   output logic                                 rsp_overflow,
   input  logic                                 csr_wr_en,
   input  logic [sedb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sedb_pkg::TICK_WIDTH-1:0]      csr_wdata
);
   import sedb_pkg::*;

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   sedb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_cell_id    (req_cell_id),
      .req_spike_time (req_spike_time),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   sedb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_id_out   (rsp_cell_id_out),
      .rsp_time_in_frame (rsp_time_in_frame),
      .rsp_has_spike     (rsp_has_spike),
      .rsp_last          (rsp_last),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

>>> rtl/sedb_checker.sv
// Port-level checker for the spike event delay buffer, bound to the top level.
`include "spike_event_delay_buffer_top_macros.svh"

module sedb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sedb_pkg::CELL_WIDTH-1:0] rsp_cell_id_out,
   input logic [sedb_pkg::TICK_WIDTH-1:0] rsp_time_in_frame,
   input logic                            rsp_has_spike,
   input logic                            rsp_last,
   input logic                            rsp_overflow
);
   import sedb_pkg::*;

   // A stalled result transaction keeps its contents.
   `SEDB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_cell_id_out, rsp_time_in_frame, rsp_has_spike, rsp_last, rsp_overflow}), "stalled result changed")

   // An empty frame result is the only result of its frame and carries zeros.
   `SEDB_ASSERT_SAME(a_empty_result, clock, reset, rsp_valid && !rsp_has_spike, rsp_last && (rsp_cell_id_out == '0) && (rsp_time_in_frame == '0), "malformed empty result")

   // No result is offered right after reset.
   `SEDB_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // The overflow mark is the same on every result of one frame.
   `SEDB_ASSERT_NEXT(a_ovf_frame, clock, reset, rsp_valid && !rsp_stall && !rsp_last, !rsp_valid || (rsp_overflow == $past(rsp_overflow)), "overflow changed within a frame")

endmodule

bind spike_event_delay_buffer_top sedb_checker u_checker (.*);

>>> verif/spike_event_delay_buffer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the spike event delay buffer: directed cases, then random traffic.
module spike_event_delay_buffer_top_tb;
   import sedb_pkg::*;

   typedef struct packed {
      logic [CELL_WIDTH-1:0] cell_id;
      logic [TICK_WIDTH-1:0] time_in_frame;
      logic                  has_spike;
      logic                  last;
      logic                  overflow;
   } delayed_spike_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic                       req_kind       = 1'b0;
   logic [CELL_WIDTH-1:0]      req_cell_id    = '0;
   logic [TICK_WIDTH-1:0]      req_spike_time = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic [CELL_WIDTH-1:0]      rsp_cell_id_out;
   logic [TICK_WIDTH-1:0]      rsp_time_in_frame;
   logic                       rsp_has_spike;
   logic                       rsp_last;
   logic                       rsp_overflow;
   logic                       csr_wr_en      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [TICK_WIDTH-1:0]      csr_wdata      = '0;

   logic [TICK_WIDTH-1:0] model_delay = TICK_WIDTH'(1);
   logic [TICK_WIDTH-1:0] model_frame = TICK_WIDTH'(1);
   logic [CELL_WIDTH-1:0] held_cell [RING_DEPTH];
   logic [TIME_WIDTH-1:0] held_due [RING_DEPTH];
   int                    head_idx = 0;
   int                    tail_idx = 0;
   logic [TIME_WIDTH-1:0] frame_origin = '0;
   logic                  spikes_dropped = 1'b0;
   delayed_spike_type     pending_spikes [$];

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int error_count     = 0;
   int items_sent      = 0;
   int results_seen    = 0;
   int overflow_frames = 0;
   int late_spikes     = 0;

   spike_event_delay_buffer_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_cell_id       (req_cell_id),
      .req_spike_time    (req_spike_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_id_out   (rsp_cell_id_out),
      .rsp_time_in_frame (rsp_time_in_frame),
      .rsp_has_spike     (rsp_has_spike),
      .rsp_last          (rsp_last),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic model_item(input op_type kind, input logic [CELL_WIDTH-1:0] cell_id,
                             input logic [TICK_WIDTH-1:0] stime);
      int                    nxt;
      logic [TIME_WIDTH-1:0] gap_ticks;
      logic [TICK_WIDTH-1:0] rel;
      logic                  ovf;
      bit                    due;
      delayed_spike_type     r;
      delayed_spike_type     frame_out [$];
      if (kind == OP_SPIKE) begin
         nxt = (tail_idx + 1) % RING_DEPTH;
         if (nxt == head_idx) begin
            spikes_dropped = 1'b1;
         end else begin
            held_cell[tail_idx] = cell_id;
            held_due[tail_idx]  = frame_origin + TIME_WIDTH'(model_delay) + TIME_WIDTH'(stime);
            tail_idx = nxt;
         end
      end else begin
         ovf = spikes_dropped;
         due = 1'b1;
         while (due && head_idx != tail_idx && frame_out.size() < RING_DEPTH - 1) begin
            gap_ticks = held_due[head_idx] - frame_origin;
            rel = '0;
            if (gap_ticks[TIME_WIDTH-1]) begin
               late_spikes++;
            end else if (gap_ticks < TIME_WIDTH'(model_frame)) begin
               rel = gap_ticks[TICK_WIDTH-1:0];
            end else begin
               due = 1'b0;
            end
            if (due) begin
               r.cell_id       = held_cell[head_idx];
               r.time_in_frame = rel;
               r.has_spike     = 1'b1;
               r.last          = 1'b0;
               r.overflow      = ovf;
               frame_out.push_back(r);
               head_idx = (head_idx + 1) % RING_DEPTH;
            end
         end
         if (frame_out.size() == 0) begin
            r.cell_id       = '0;
            r.time_in_frame = '0;
            r.has_spike     = 1'b0;
            r.last          = 1'b1;
            r.overflow      = ovf;
            frame_out.push_back(r);
         end else begin
            frame_out[frame_out.size()-1].last = 1'b1;
         end
         if (ovf) begin
            overflow_frames++;
         end
         foreach (frame_out[i]) begin
            pending_spikes.push_back(frame_out[i]);
         end
         spikes_dropped = 1'b0;
         frame_origin   = frame_origin + TIME_WIDTH'(model_frame);
      end
   endtask

   always @(posedge clock) begin : check_results
      delayed_spike_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_spikes.size() == 0) begin
            $error("unexpected result transaction: cell_id_out %h, time_in_frame %h",
                   rsp_cell_id_out, rsp_time_in_frame);
            error_count++;
         end else begin
            want = pending_spikes.pop_front();
            results_seen++;
            if (rsp_cell_id_out !== want.cell_id) begin
               $error("cell_id_out: expected %h, actual %h", want.cell_id, rsp_cell_id_out);
               error_count++;
            end
            if (rsp_time_in_frame !== want.time_in_frame) begin
               $error("time_in_frame: expected %h, actual %h", want.time_in_frame,
                      rsp_time_in_frame);
               error_count++;
            end
            if (rsp_has_spike !== want.has_spike) begin
               $error("has_spike: expected %b, actual %b", want.has_spike, rsp_has_spike);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_last);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %b, actual %b", want.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   task automatic send_item(input op_type kind, input logic [CELL_WIDTH-1:0] cell_id,
                            input logic [TICK_WIDTH-1:0] stime);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_cell_id    <= cell_id;
      req_spike_time <= stime;
      do @(posedge clock); while (req_stall);
      model_item(kind, cell_id, stime);
      items_sent++;
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_spikes.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [TICK_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_DELAY_TICKS) begin
         model_delay = value;
      end else begin
         model_frame = value;
      end
   endtask

   task automatic set_ticks(input logic [TICK_WIDTH-1:0] delay_value,
                            input logic [TICK_WIDTH-1:0] frame_value);
      drain_block();
      write_register(CSR_DELAY_TICKS, delay_value);
      write_register(CSR_FRAME_TICKS, frame_value);
   endtask

   function automatic logic [TICK_WIDTH-1:0] pick_ticks();
      case ($urandom_range(5))
         0: return TICK_WIDTH'(1);
         1: return '1;
         2: return TICK_WIDTH'($urandom_range(1, 16));
         3: return TICK_WIDTH'($urandom_range(17, 4096));
         4: return TICK_WIDTH'($urandom_range(1, 1048575));
         default: return TICK_WIDTH'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [TICK_WIDTH-1:0] pick_spike_time();
      longint unsigned cap;
      cap = 2 * longint'(model_frame) + 1;
      if (cap > 1048575) begin
         cap = 1048575;
      end
      case ($urandom_range(9))
         0: return TICK_WIDTH'($urandom);
         1: return $urandom_range(1) ? '1 : '0;
         default: return TICK_WIDTH'($urandom_range(0, int'(cap)));
      endcase
   endfunction

   task automatic random_setting();
      logic [TICK_WIDTH-1:0] frame_value;
      logic [TICK_WIDTH-1:0] delay_value;
      longint unsigned       cap;
      frame_value = pick_ticks();
      cap = 3 * longint'(frame_value);
      if (cap > 1048575) begin
         cap = 1048575;
      end
      if ($urandom_range(3) == 0) begin
         delay_value = pick_ticks();
      end else begin
         delay_value = TICK_WIDTH'($urandom_range(0, int'(cap)));
      end
      set_ticks(delay_value, frame_value);
   endtask

   task automatic random_frames(input int count);
      int first;
      int burst;
      first = items_sent;
      while (items_sent - first < count) begin
         burst = ($urandom_range(11) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 6);
         repeat (burst) send_item(OP_SPIKE, CELL_WIDTH'($urandom), pick_spike_time());
         if ($urandom_range(9) != 0) begin
            send_item(OP_FRAME_END, CELL_WIDTH'($urandom), TICK_WIDTH'($urandom));
         end
      end
   endtask

   task automatic test_reset_values();
      send_item(OP_FRAME_END, '0, '0);
      send_item(OP_SPIKE, '1, '0);
      send_item(OP_FRAME_END, '1, '1);
      send_item(OP_FRAME_END, '0, '0);
      drain_block();
   endtask

   task automatic test_register_extremes();
      set_ticks('0, '1);
      send_item(OP_SPIKE, 16'hA5A5, 20'h5A5A5);
      send_item(OP_SPIKE, 16'h0000, '1);
      send_item(OP_SPIKE, 16'hFFFF, '0);
      send_item(OP_FRAME_END, '0, '0);
      send_item(OP_FRAME_END, '0, '0);
      set_ticks('1, '1);
      send_item(OP_SPIKE, 16'h1234, '0);
      send_item(OP_SPIKE, 16'h4321, '1);
      repeat (4) send_item(OP_FRAME_END, '0, '0);
      set_ticks(TICK_WIDTH'(1), TICK_WIDTH'(1));
   endtask

   task automatic test_late_spike();
      set_ticks(TICK_WIDTH'(1), TICK_WIDTH'(10));
      send_item(OP_SPIKE, 16'h0101, TICK_WIDTH'(15));
      send_item(OP_SPIKE, 16'h0202, TICK_WIDTH'(0));
      send_item(OP_SPIKE, 16'h0303, TICK_WIDTH'(9));
      send_item(OP_FRAME_END, '0, '0);
      send_item(OP_FRAME_END, '0, '0);
      send_item(OP_FRAME_END, '0, '0);
      drain_block();
   endtask

   task automatic test_zero_frame();
      set_ticks('0, '0);
      send_item(OP_SPIKE, 16'h00FF, '0);
      send_item(OP_SPIKE, 16'hFF00, TICK_WIDTH'(3));
      send_item(OP_FRAME_END, '0, '0);
      send_item(OP_FRAME_END, '0, '0);
      set_ticks('0, TICK_WIDTH'(5));
      send_item(OP_FRAME_END, '0, '0);
      drain_block();
   endtask

   task automatic test_ring_full();
      set_ticks(TICK_WIDTH'(1), TICK_WIDTH'(1000));
      for (int i = 0; i < RING_DEPTH + 1; i++) begin
         send_item(OP_SPIKE, CELL_WIDTH'($urandom), TICK_WIDTH'(i));
      end
      send_item(OP_FRAME_END, '0, '0);
      send_item(OP_FRAME_END, '0, '0);
      set_ticks(TICK_WIDTH'(2000), TICK_WIDTH'(1000));
      for (int i = 0; i < RING_DEPTH; i++) begin
         send_item(OP_SPIKE, CELL_WIDTH'($urandom), '0);
      end
      repeat (3) send_item(OP_FRAME_END, '0, '0);
      drain_block();
   endtask

   task automatic test_random_traffic();
      int idle_plan  [4] = '{0, 84, 0, 17};
      int stall_plan [4] = '{0, 0, 84, 17};
      for (int p = 0; p < 4; p++) begin
         drain_block();
         send_idle_pct = idle_plan[p];
         stall_pct     = stall_plan[p];
         random_setting();
         random_frames(8);
         random_setting();
         random_frames(8);
      end
      drain_block();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_register_extremes();
      test_late_spike();
      test_zero_frame();
      test_ring_full();
      test_random_traffic();
      drain_block();
      $display("Sent %0d transactions and checked %0d results, with %0d frames reporting drops",
               items_sent, results_seen, overflow_frames);
      $display("and %0d late spikes, across idle, sender-gap, receiver-stall and mixed phases.",
               late_spikes);
      if (error_count == 0 && pending_spikes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
